// ===== design/sha1_pkg.sv =====
package sha1_pkg;

    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned RING_DEPTH = 16;
    localparam int unsigned LEN_BYTE_W = 61;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND   = 7'(ROUNDS - 1);
    localparam logic [5:0] LAST_BYTE    = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [2:0] LAST_WORD_IX = 3'd4;

    // Five 32-bit words, index 0 is h0 (or a).
    typedef logic [4:0][31:0] t_chain;

    localparam t_chain H_INIT = {H4, H3, H2, H1, H0};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       final_item;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_overflow;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PRIME,
        ST_ROUND,
        ST_FINISH,
        ST_DIGEST
    } t_state;

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [3:0] a0;
        logic [3:0] a1;
        logic [3:0] a2;
        logic [3:0] a3;
    } t_rd_addr;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_rd_data;

    typedef struct packed {
        logic       init;
        logic       step;
        logic       clear;
        logic [6:0] round;
    } t_round_ctl;

    typedef struct packed {
        logic finish;
        logic to_digest;
        logic overflow;
    } t_ctrl_stat;

endpackage

// ===== design/sha1_sched_mem.sv =====
module sha1_sched_mem (
    input  logic               i_clk,
    input  sha1_pkg::t_mem_wr  i_wr,
    input  sha1_pkg::t_rd_addr i_rd_addr,
    output sha1_pkg::t_rd_data o_rd_data
);

    // Two identical copies of the ring give four read ports in total.
    logic [31:0] r_ring_a [sha1_pkg::RING_DEPTH];
    logic [31:0] r_ring_b [sha1_pkg::RING_DEPTH];
    sha1_pkg::t_rd_data r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ring_a[i_wr.addr] <= i_wr.data;
            r_ring_b[i_wr.addr] <= i_wr.data;
        end
        r_rd.w0 <= r_ring_a[i_rd_addr.a0];
        r_rd.w1 <= r_ring_a[i_rd_addr.a1];
        r_rd.w2 <= r_ring_b[i_rd_addr.a2];
        r_rd.w3 <= r_ring_b[i_rd_addr.a3];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== design/sha1_round_dp.sv =====
module sha1_round_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1_pkg::t_round_ctl i_ctl,
    input  sha1_pkg::t_chain     i_chain,
    input  sha1_pkg::t_rd_data   i_rd,
    output sha1_pkg::t_chain     o_work,
    output sha1_pkg::t_mem_wr    o_wr
);

    sha1_pkg::t_chain r_work;
    sha1_pkg::t_chain n_work;
    logic [31:0] x;
    logic [31:0] w;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic        expand;

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];

    // Rounds from 16 on extend the schedule in place in the ring.
    assign expand = (i_ctl.round >= 7'd16);
    assign x      = i_rd.w0 ^ i_rd.w1 ^ i_rd.w2 ^ i_rd.w3;
    assign w      = expand ? {x[30:0], x[31]} : i_rd.w0;

    always_comb begin
        if (i_ctl.round < 7'd20) begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K0;
        end else if (i_ctl.round < 7'd40) begin
            f = b ^ c ^ d;
            k = sha1_pkg::K1;
        end else if (i_ctl.round < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K2;
        end else begin
            f = b ^ c ^ d;
            k = sha1_pkg::K3;
        end
    end

    assign t = {a[26:0], a[31:27]} + f + e + k + w;

    always_comb begin
        n_work = r_work;
        if (i_ctl.clear) begin
            n_work = '0;
        end else if (i_ctl.init) begin
            n_work = i_chain;
        end else if (i_ctl.step) begin
            n_work[0] = t;
            n_work[1] = a;
            n_work[2] = {b[1:0], b[31:2]};
            n_work[3] = c;
            n_work[4] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
        end else begin
            r_work <= n_work;
        end
    end

    assign o_work    = r_work;
    assign o_wr.en   = i_ctl.step && expand;
    assign o_wr.addr = i_ctl.round[3:0];
    assign o_wr.data = w;

endmodule

// ===== design/sha1_ctrl.sv =====
module sha1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sha1_pkg::t_in        i_in_data,
    input  logic                 i_digest_done,
    output sha1_pkg::t_round_ctl o_ctl,
    output sha1_pkg::t_mem_wr    o_pack_wr,
    output sha1_pkg::t_rd_addr   o_rd_addr,
    output sha1_pkg::t_ctrl_stat o_stat
);

    sha1_pkg::t_state r_state;
    sha1_pkg::t_state n_state;
    sha1_pkg::t_state r_after;
    sha1_pkg::t_state n_after;

    logic [5:0]                      r_count;
    logic [5:0]                      n_count;
    logic [23:0]                     r_pack;
    logic [23:0]                     n_pack;
    logic [sha1_pkg::LEN_BYTE_W-1:0] r_len;
    logic [sha1_pkg::LEN_BYTE_W-1:0] n_len;
    logic [6:0]                      r_round;
    logic [6:0]                      n_round;
    logic                            r_ovf;
    logic                            n_ovf;
    logic                            r_mark;
    logic                            n_mark;
    logic                            r_len_phase;
    logic                            n_len_phase;

    logic        push_en;
    logic [7:0]  push_byte;
    logic [31:0] packed_word;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic        len_full;
    logic        accept;
    logic [3:0]  next_ix;

    assign accept   = i_in_valid && o_in_ready;
    assign len_full = &r_len;
    assign len_bits = {r_len, 3'b000};
    assign len_byte = len_bits[{~r_count[2:0], 3'b000} +: 8];

    assign packed_word = {r_pack, push_byte};

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_count     = r_count;
        n_pack      = r_pack;
        n_len       = r_len;
        n_round     = r_round;
        n_ovf       = r_ovf;
        n_mark      = r_mark;
        n_len_phase = r_len_phase;
        push_en     = 1'b0;
        push_byte   = '0;
        o_in_ready  = 1'b0;
        o_ctl       = '0;
        o_stat      = '0;

        unique case (r_state)
            sha1_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    if (i_in_data.has_byte) begin
                        if (len_full) begin
                            // The byte is dropped and the digest carries the flag.
                            n_ovf = 1'b1;
                        end else begin
                            push_en   = 1'b1;
                            push_byte = i_in_data.data_byte;
                            n_len     = r_len + 1'b1;
                        end
                    end
                    if (push_en && r_count == sha1_pkg::LAST_BYTE) begin
                        n_state = sha1_pkg::ST_PRIME;
                        n_after = i_in_data.final_item ? sha1_pkg::ST_PAD
                                                       : sha1_pkg::ST_IDLE;
                    end else if (i_in_data.final_item) begin
                        n_state = sha1_pkg::ST_PAD;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                push_en = 1'b1;
                if (!r_mark) begin
                    push_byte = sha1_pkg::PAD_MARK;
                    n_mark    = 1'b1;
                end else if (r_len_phase || r_count == sha1_pkg::LEN_POS) begin
                    push_byte   = len_byte;
                    n_len_phase = 1'b1;
                end
                if (r_count == sha1_pkg::LAST_BYTE) begin
                    n_state = sha1_pkg::ST_PRIME;
                    n_after = n_len_phase ? sha1_pkg::ST_DIGEST : sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_PRIME: begin
                o_ctl.init = 1'b1;
                n_round    = '0;
                n_state    = sha1_pkg::ST_ROUND;
            end
            sha1_pkg::ST_ROUND: begin
                o_ctl.step = 1'b1;
                n_round    = r_round + 7'd1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = '0;
                    n_state = sha1_pkg::ST_FINISH;
                end
            end
            sha1_pkg::ST_FINISH: begin
                o_stat.finish = 1'b1;
                n_state       = r_after;
            end
            sha1_pkg::ST_DIGEST: begin
                if (i_digest_done) begin
                    o_ctl.clear = 1'b1;
                    n_count     = '0;
                    n_len       = '0;
                    n_ovf       = 1'b0;
                    n_mark      = 1'b0;
                    n_len_phase = 1'b0;
                    n_after     = sha1_pkg::ST_IDLE;
                    n_state     = sha1_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase

        if (push_en) begin
            n_pack  = packed_word[23:0];
            n_count = r_count + 6'd1;
        end

        o_ctl.round      = r_round;
        o_stat.to_digest = (r_after == sha1_pkg::ST_DIGEST);
        o_stat.overflow  = r_ovf;
    end

    // A word goes to the ring once its fourth byte is in.
    assign o_pack_wr.en   = push_en && (r_count[1:0] == 2'b11);
    assign o_pack_wr.addr = r_count[5:2];
    assign o_pack_wr.data = packed_word;

    // Reads are issued in the cycle before the round that uses them.
    assign next_ix      = (r_state == sha1_pkg::ST_ROUND) ? r_round[3:0] + 4'd1 : 4'd0;
    assign o_rd_addr.a0 = next_ix;
    assign o_rd_addr.a1 = next_ix + 4'd13;
    assign o_rd_addr.a2 = next_ix + 4'd8;
    assign o_rd_addr.a3 = next_ix + 4'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1_pkg::ST_IDLE;
            r_after     <= sha1_pkg::ST_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_round     <= '0;
            r_ovf       <= 1'b0;
            r_mark      <= 1'b0;
            r_len_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_count     <= n_count;
            r_len       <= n_len;
            r_round     <= n_round;
            r_ovf       <= n_ovf;
            r_mark      <= n_mark;
            r_len_phase <= n_len_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack <= n_pack;
    end

endmodule

// ===== design/sha1_stream_hasher_core.sv =====
// Channel   Direction  Payload           Handshake
// in        input      sha1_pkg::t_in    i_in_valid / o_in_ready
// out       output     sha1_pkg::t_out   o_out_valid / i_out_ready
//
// A byte that does not complete a block is taken without holding the input; the 64th
// byte then holds the input while the block is compressed: a prime state for the ring
// read, the 80 rounds and a finish state that folds the work words into the chain.
// A final transaction pads one byte per cycle (up to 72 bytes, one or two more
// compressions), then offers the five digest words; input waits for the last one.
// Reset is synchronous; the schedule ring is not cleared. The out side may stall.
module sha1_stream_hasher_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sha1_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sha1_pkg::t_out o_out_data
);

    sha1_pkg::t_round_ctl ctl;
    sha1_pkg::t_ctrl_stat stat;
    sha1_pkg::t_mem_wr    pack_wr;
    sha1_pkg::t_mem_wr    dp_wr;
    sha1_pkg::t_mem_wr    mem_wr;
    sha1_pkg::t_rd_addr   rd_addr;
    sha1_pkg::t_rd_data   rd_data;
    sha1_pkg::t_chain     work;

    sha1_pkg::t_chain r_chain;
    sha1_pkg::t_chain n_chain;
    sha1_pkg::t_out   r_out;
    sha1_pkg::t_out   n_out;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             digest_done;
    logic [2:0]       next_word;

    sha1_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_digest_done (digest_done),
        .o_ctl         (ctl),
        .o_pack_wr     (pack_wr),
        .o_rd_addr     (rd_addr),
        .o_stat        (stat)
    );

    sha1_round_dp u_round_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_chain (r_chain),
        .i_rd    (rd_data),
        .o_work  (work),
        .o_wr    (dp_wr)
    );

    // Byte packing and schedule extension never write in the same cycle.
    assign mem_wr = dp_wr.en ? dp_wr : pack_wr;

    sha1_sched_mem u_sched_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign digest_done = r_out_valid && i_out_ready && r_out.last_word;
    assign next_word   = r_out.word_index + 3'd1;

    always_comb begin
        n_chain     = r_chain;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (stat.finish) begin
            for (int i = 0; i < 5; i++) begin
                n_chain[i] = r_chain[i] + work[i];
            end
            if (stat.to_digest) begin
                n_out_valid           = 1'b1;
                n_out.digest_word     = n_chain[0];
                n_out.word_index      = '0;
                n_out.last_word       = 1'b0;
                n_out.length_overflow = stat.overflow;
            end
        end

        if (r_out_valid && i_out_ready) begin
            if (r_out.last_word) begin
                n_out_valid = 1'b0;
                n_chain     = sha1_pkg::H_INIT;
            end else begin
                n_out.digest_word = r_chain[next_word];
                n_out.word_index  = next_word;
                n_out.last_word   = (next_word == sha1_pkg::LAST_WORD_IX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= sha1_pkg::H_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
